// ===== design/lqi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqi_pkg
// Shared types, constants and the microcode program of the LQI controller.
// ----------------------------------------------------------------------------
package lqi_pkg;

    // Fixed sizes of the ports and of the arithmetic.
    localparam int MAX_STATES       = 6;
    localparam int MAX_COMMANDS     = 3;
    localparam int NUM_TRACKED      = 3;
    localparam int DEF_NUM_STATES   = 6;
    localparam int DEF_NUM_COMMANDS = 3;

    localparam int WORD_W  = 16;
    localparam int CMD_W   = 32;
    localparam int INTEG_W = 32;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = 52;
    localparam int ROW_W   = 2;
    localparam int COL_W   = 3;
    localparam int TRK_IW  = 2;
    localparam int UPC_W   = 3;

    localparam logic [WORD_W-1:0] PERIOD_RESET = 16'd655;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_B  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_C  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd3;

    // Item codes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_STEP  = 1'b1;
    localparam logic MATRIX_FB  = 1'b0;
    localparam logic MATRIX_TRK = 1'b1;

    typedef logic signed [WORD_W-1:0]  t_word;
    typedef logic signed [CMD_W-1:0]   t_cmd;
    typedef logic [UPC_W-1:0]          t_upc;

    // Datapath operations, one per microcode step.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INT_MUL,
        OP_INT_ACC,
        OP_TRK_MAC,
        OP_FB_MAC,
        OP_FLUSH,
        OP_CMD,
        OP_DONE
    } t_op;

    // Loop conditions: the jump is taken while the index is not yet at its last value.
    typedef enum logic [1:0] {
        C_NONE,
        C_COL_TRK,
        C_COL_ST,
        C_ROW
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic             start;
        t_op              op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_ctrl;

    // One gain word write.
    typedef struct packed {
        logic             we;
        logic             matrix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_word            value;
    } t_load;

    // One configuration register write.
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
    } t_cfg_wr;

    // Program entry points.
    localparam t_upc UPC_INT    = 3'd0;
    localparam t_upc UPC_TRK    = 3'd2;
    localparam t_upc UPC_FB     = 3'd3;
    localparam t_upc UCODE_LAST = 3'd6;

    // The control program. Integrators first, then one pass per command row.
    function automatic t_uword ucode(input t_upc pc);
        t_uword uw;
        unique case (pc)
            3'd0:    uw = '{op: OP_INT_MUL, cond: C_NONE,    target: UPC_INT};
            3'd1:    uw = '{op: OP_INT_ACC, cond: C_COL_TRK, target: UPC_INT};
            3'd2:    uw = '{op: OP_TRK_MAC, cond: C_COL_TRK, target: UPC_TRK};
            3'd3:    uw = '{op: OP_FB_MAC,  cond: C_COL_ST,  target: UPC_FB};
            3'd4:    uw = '{op: OP_FLUSH,   cond: C_NONE,    target: UPC_INT};
            3'd5:    uw = '{op: OP_CMD,     cond: C_ROW,     target: UPC_TRK};
            default: uw = '{op: OP_DONE,    cond: C_NONE,    target: UPC_INT};
        endcase
        return uw;
    endfunction

endpackage

// ===== design/lqi_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqi_datapath
// Gain and integrator storage with one shared product register and accumulator,
// driven one operation per cycle by the microcode sequencer.
// ----------------------------------------------------------------------------
module lqi_datapath #(
    parameter int NUM_STATES   = lqi_pkg::DEF_NUM_STATES,
    parameter int NUM_COMMANDS = lqi_pkg::DEF_NUM_COMMANDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lqi_pkg::t_cfg_wr i_cfg,
    input  lqi_pkg::t_load   i_load,
    input  lqi_pkg::t_ctrl   i_ctrl,
    input  lqi_pkg::t_word   i_state [NUM_STATES],
    output lqi_pkg::t_cmd    o_cmd [NUM_COMMANDS],
    output logic             o_sat
);

    localparam int ST_IW  = $clog2(NUM_STATES);
    localparam int ROW_IW = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;
    localparam logic [lqi_pkg::COL_W-1:0] NST  = lqi_pkg::COL_W'(NUM_STATES);
    localparam logic [lqi_pkg::COL_W-1:0] NTRK = lqi_pkg::COL_W'(lqi_pkg::NUM_TRACKED);
    localparam logic [lqi_pkg::ROW_W-1:0] NCMD = lqi_pkg::ROW_W'(NUM_COMMANDS);

    lqi_pkg::t_word                      r_ref [lqi_pkg::NUM_TRACKED];
    logic [lqi_pkg::WORD_W-1:0]          r_period;
    lqi_pkg::t_word                      r_kfb [NUM_COMMANDS][NUM_STATES];
    lqi_pkg::t_word                      r_ktr [NUM_COMMANDS][lqi_pkg::NUM_TRACKED];
    logic signed [lqi_pkg::INTEG_W-1:0]  r_integ [lqi_pkg::NUM_TRACKED];
    lqi_pkg::t_word                      r_st [NUM_STATES];
    logic signed [lqi_pkg::PROD_W-1:0]   r_prod;
    logic                                r_prod_vld;
    logic signed [lqi_pkg::ACC_W-1:0]    r_acc;
    lqi_pkg::t_cmd                       r_cmd [NUM_COMMANDS];
    logic                                r_sat;

    logic [ROW_IW-1:0]          w_ri;
    logic [ST_IW-1:0]           w_ci_st;
    logic [lqi_pkg::TRK_IW-1:0] w_ci_tr;
    logic [ROW_IW-1:0]          w_ld_ri;
    logic [ST_IW-1:0]           w_ld_ci_st;
    logic [lqi_pkg::TRK_IW-1:0] w_ld_ci_tr;
    logic                       w_ld_row_ok;

    logic signed [16:0] w_diff;
    logic signed [33:0] w_int_prod;
    logic signed [34:0] w_int_rnd;
    logic signed [18:0] w_inc;
    logic signed [32:0] w_isum;
    logic               w_iovf;
    logic signed [lqi_pkg::INTEG_W-1:0] w_isat;
    logic signed [47:0] w_trk;
    logic signed [16:0] w_nst;
    logic signed [32:0] w_fb;
    logic signed [lqi_pkg::ACC_W-1:0] w_acc_add;
    logic signed [lqi_pkg::ACC_W-1:0] w_crnd;
    logic signed [43:0] w_cval;
    logic               w_covf;
    lqi_pkg::t_cmd      w_csat;

    // Table indexes, cut down to the bits that each depth needs.
    assign w_ri       = i_ctrl.row[ROW_IW-1:0];
    assign w_ci_st    = i_ctrl.col[ST_IW-1:0];
    assign w_ci_tr    = i_ctrl.col[lqi_pkg::TRK_IW-1:0];
    assign w_ld_ri    = i_load.row[ROW_IW-1:0];
    assign w_ld_ci_st = i_load.col[ST_IW-1:0];
    assign w_ld_ci_tr = i_load.col[lqi_pkg::TRK_IW-1:0];
    assign w_ld_row_ok = (i_load.row < NCMD);

    // Integrator increment: (reference - state) * period, rounded to Q.12.
    assign w_diff     = {r_ref[w_ci_tr][15], r_ref[w_ci_tr]}
                      - {r_st[w_ci_st][15], r_st[w_ci_st]};
    assign w_int_prod = w_diff * $signed({1'b0, r_period});
    assign w_int_rnd  = {r_prod[33], r_prod[33:0]} + 35'sd32768;
    assign w_inc      = w_int_rnd[34:16];

    // Saturating integrator update.
    assign w_isum = {r_integ[w_ci_tr][31], r_integ[w_ci_tr]} + {{14{w_inc[18]}}, w_inc};
    assign w_iovf = (w_isum[32] != w_isum[31]);
    assign w_isat = w_iovf ? (w_isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                           : w_isum[31:0];

    // Products for the command sums; the feedback term is negated at the operand.
    assign w_trk = r_ktr[w_ri][w_ci_tr] * r_integ[w_ci_tr];
    assign w_nst = -$signed({r_st[w_ci_st][15], r_st[w_ci_st]});
    assign w_fb  = r_kfb[w_ri][w_ci_st] * w_nst;

    // The accumulator takes the product of the previous step.
    assign w_acc_add = r_prod_vld ? (r_acc + {{4{r_prod[47]}}, r_prod}) : r_acc;

    // Command rounding from Q.20 to Q.12 and saturation.
    assign w_crnd = r_acc + 52'sd128;
    assign w_cval = w_crnd[51:8];
    assign w_covf = !((&w_cval[43:31]) || (~|w_cval[43:31]));
    assign w_csat = w_covf ? (w_cval[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                           : w_cval[31:0];

    // Registers, gain tables and the operation decoder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < lqi_pkg::NUM_TRACKED; t++) begin
                r_ref[t]   <= '0;
                r_integ[t] <= '0;
            end
            r_period <= lqi_pkg::PERIOD_RESET;
            for (int r = 0; r < NUM_COMMANDS; r++) begin
                for (int c = 0; c < NUM_STATES; c++) begin
                    r_kfb[r][c] <= '0;
                end
                for (int c = 0; c < lqi_pkg::NUM_TRACKED; c++) begin
                    r_ktr[r][c] <= '0;
                end
            end
            r_prod_vld <= 1'b0;
            r_sat      <= 1'b0;
        end else begin
            // Configuration writes; an unknown index has no effect.
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    lqi_pkg::CFG_REF_A:  r_ref[0] <= i_cfg.data;
                    lqi_pkg::CFG_REF_B:  r_ref[1] <= i_cfg.data;
                    lqi_pkg::CFG_REF_C:  r_ref[2] <= i_cfg.data;
                    lqi_pkg::CFG_PERIOD: r_period <= i_cfg.data;
                    default: ;
                endcase
            end

            // Gain word loads; out-of-range rows and columns are dropped.
            if (i_load.we && w_ld_row_ok) begin
                if (i_load.matrix == lqi_pkg::MATRIX_FB) begin
                    if (i_load.col < NST) begin
                        r_kfb[w_ld_ri][w_ld_ci_st] <= i_load.value;
                    end
                end else if (i_load.col < NTRK) begin
                    r_ktr[w_ld_ri][w_ld_ci_tr] <= i_load.value;
                end
            end

            // A new control step captures its state vector.
            if (i_ctrl.start) begin
                r_sat <= 1'b0;
                for (int s = 0; s < NUM_STATES; s++) begin
                    r_st[s] <= i_state[s];
                end
            end

            unique case (i_ctrl.op)
                lqi_pkg::OP_INT_MUL: begin
                    r_prod <= {{14{w_int_prod[33]}}, w_int_prod};
                end
                lqi_pkg::OP_INT_ACC: begin
                    r_integ[w_ci_tr] <= w_isat;
                    if (w_iovf) begin
                        r_sat <= 1'b1;
                    end
                    r_acc      <= '0;
                    r_prod_vld <= 1'b0;
                end
                lqi_pkg::OP_TRK_MAC: begin
                    r_acc      <= w_acc_add;
                    r_prod     <= w_trk;
                    r_prod_vld <= 1'b1;
                end
                lqi_pkg::OP_FB_MAC: begin
                    r_acc      <= w_acc_add;
                    r_prod     <= {{15{w_fb[32]}}, w_fb};
                    r_prod_vld <= 1'b1;
                end
                lqi_pkg::OP_FLUSH: begin
                    r_acc      <= w_acc_add;
                    r_prod_vld <= 1'b0;
                end
                lqi_pkg::OP_CMD: begin
                    r_cmd[w_ri] <= w_csat;
                    if (w_covf) begin
                        r_sat <= 1'b1;
                    end
                    r_acc <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_cmd = r_cmd;
    assign o_sat = r_sat;

endmodule

// ===== design/lqi_state_feedback_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqi_state_feedback_controller_top
// State-feedback controller with integral tracking: a microcoded sequencer
// steps one shared multiply-accumulate datapath through each control step.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Beat
//  input     in         i_valid / o_ready   gain load (mode 0) or control step (mode 1)
//  output    out        o_valid / i_ready   three commands and the saturation flag
//  config    in         i_cfg_we            one register write, taken at once
//
// A gain load gives no output beat. A control step runs the microcode program:
// the integrator updates, then per command row the tracking sum, the feedback
// sum, a flush and the command, then the final step; the input stays closed
// until the sequencer is idle again. A finished result sits in the output
// register, and further beats are accepted while it waits; the sequencer only
// holds at its final step if the previous result is still untaken. Reset is
// synchronous and clears gains, integrators and references.
// ----------------------------------------------------------------------------
module lqi_state_feedback_controller_top #(
    parameter int NUM_STATES   = lqi_pkg::DEF_NUM_STATES,
    parameter int NUM_COMMANDS = lqi_pkg::DEF_NUM_COMMANDS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port
    input  logic                             i_cfg_we,
    input  logic [lqi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lqi_pkg::WORD_W-1:0]       i_cfg_data,
    // Input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic                             i_gain_matrix,
    input  logic [lqi_pkg::ROW_W-1:0]        i_gain_row,
    input  logic [lqi_pkg::COL_W-1:0]        i_gain_col,
    input  logic signed [15:0]               i_gain_value,
    input  logic signed [15:0]               i_state_0,
    input  logic signed [15:0]               i_state_1,
    input  logic signed [15:0]               i_state_2,
    input  logic signed [15:0]               i_state_3,
    input  logic signed [15:0]               i_state_4,
    input  logic signed [15:0]               i_state_5,
    // Output channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [31:0]               o_command_0,
    output logic signed [31:0]               o_command_1,
    output logic signed [31:0]               o_command_2,
    output logic                             o_saturated
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                      r_state;
    lqi_pkg::t_upc               r_pc;
    logic [lqi_pkg::ROW_W-1:0]   r_row;
    logic [lqi_pkg::COL_W-1:0]   r_col;
    logic                        r_out_valid;
    lqi_pkg::t_cmd               r_cmd [NUM_COMMANDS];
    logic                        r_sat;

    lqi_pkg::t_upc               n_pc;
    logic [lqi_pkg::ROW_W-1:0]   n_row;
    logic [lqi_pkg::COL_W-1:0]   n_col;

    lqi_pkg::t_uword  w_uw;
    logic             w_in_acc;
    logic             w_step_acc;
    logic             w_slot_free;
    logic             w_at_done;
    logic             w_done_go;
    logic             w_taken;
    logic             w_last_trk;
    logic             w_last_st;
    logic             w_last_row;
    lqi_pkg::t_ctrl   w_ctrl;
    lqi_pkg::t_load   w_load;
    lqi_pkg::t_cfg_wr w_cfg;
    lqi_pkg::t_word   w_state_all [lqi_pkg::MAX_STATES];
    lqi_pkg::t_word   w_state [NUM_STATES];
    lqi_pkg::t_cmd    w_dp_cmd [NUM_COMMANDS];
    logic             w_dp_sat;
    lqi_pkg::t_cmd    w_cmd_all [lqi_pkg::MAX_COMMANDS];

    // Handshake.
    assign o_ready     = (r_state == S_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign w_step_acc  = w_in_acc && (i_mode == lqi_pkg::MODE_STEP);
    assign w_slot_free = !r_out_valid || i_ready;

    // Microcode fetch and loop conditions.
    assign w_uw       = lqi_pkg::ucode(r_pc);
    assign w_at_done  = (r_state == S_RUN) && (w_uw.op == lqi_pkg::OP_DONE);
    assign w_done_go  = w_at_done && w_slot_free;
    assign w_last_trk = (r_col == lqi_pkg::COL_W'(lqi_pkg::NUM_TRACKED - 1));
    assign w_last_st  = (r_col == lqi_pkg::COL_W'(NUM_STATES - 1));
    assign w_last_row = (r_row == lqi_pkg::ROW_W'(NUM_COMMANDS - 1));

    always_comb begin
        unique case (w_uw.cond)
            lqi_pkg::C_COL_TRK: w_taken = !w_last_trk;
            lqi_pkg::C_COL_ST:  w_taken = !w_last_st;
            lqi_pkg::C_ROW:     w_taken = !w_last_row;
            default:            w_taken = 1'b0;
        endcase
    end

    // Next program counter and loop indexes.
    always_comb begin
        n_pc  = w_taken ? w_uw.target : r_pc + 1'b1;
        n_row = r_row;
        n_col = r_col;
        unique case (w_uw.cond)
            lqi_pkg::C_COL_TRK,
            lqi_pkg::C_COL_ST: n_col = w_taken ? r_col + 1'b1 : '0;
            lqi_pkg::C_ROW:    n_row = w_taken ? r_row + 1'b1 : '0;
            default: ;
        endcase
    end

    // Sequencer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills from the final step and empties when taken.
            if (w_done_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_step_acc) begin
                        r_state <= S_RUN;
                        r_pc    <= lqi_pkg::UPC_INT;
                        r_row   <= '0;
                        r_col   <= '0;
                    end
                end
                S_RUN: begin
                    if (w_at_done) begin
                        if (w_slot_free) begin
                            r_state <= S_IDLE;
                            r_cmd   <= w_dp_cmd;
                            r_sat   <= w_dp_sat;
                        end
                    end else begin
                        r_pc  <= n_pc;
                        r_row <= n_row;
                        r_col <= n_col;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Control, load and configuration towards the datapath.
    always_comb begin
        w_ctrl.start = w_step_acc;
        w_ctrl.op    = (r_state == S_RUN) ? w_uw.op : lqi_pkg::OP_NOP;
        w_ctrl.row   = r_row;
        w_ctrl.col   = r_col;

        w_load.we     = w_in_acc && (i_mode == lqi_pkg::MODE_LOAD);
        w_load.matrix = i_gain_matrix;
        w_load.row    = i_gain_row;
        w_load.col    = i_gain_col;
        w_load.value  = i_gain_value;

        w_cfg.we   = i_cfg_we;
        w_cfg.idx  = i_cfg_index;
        w_cfg.data = i_cfg_data;
    end

    assign w_state_all[0] = i_state_0;
    assign w_state_all[1] = i_state_1;
    assign w_state_all[2] = i_state_2;
    assign w_state_all[3] = i_state_3;
    assign w_state_all[4] = i_state_4;
    assign w_state_all[5] = i_state_5;

    for (genvar s = 0; s < NUM_STATES; s++) begin : g_state
        assign w_state[s] = w_state_all[s];
    end

    lqi_datapath #(
        .NUM_STATES   (NUM_STATES),
        .NUM_COMMANDS (NUM_COMMANDS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_load  (w_load),
        .i_ctrl  (w_ctrl),
        .i_state (w_state),
        .o_cmd   (w_dp_cmd),
        .o_sat   (w_dp_sat)
    );

    // Commands beyond the configured count read as zero.
    for (genvar g = 0; g < lqi_pkg::MAX_COMMANDS; g++) begin : g_cmd
        if (g < NUM_COMMANDS) begin : g_used
            assign w_cmd_all[g] = r_cmd[g];
        end else begin : g_unused
            assign w_cmd_all[g] = '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_command_0 = w_cmd_all[0];
    assign o_command_1 = w_cmd_all[1];
    assign o_command_2 = w_cmd_all[2];
    assign o_saturated = r_sat;

    // The program counter never leaves the program.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= lqi_pkg::UCODE_LAST)
        else $error("microcode program counter out of range");

    // The row counter stays inside the configured command rows while running.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_row <= lqi_pkg::ROW_W'(NUM_COMMANDS - 1)))
        else $error("command row index out of range");

    // A control step blocks the input until it has finished.
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_acc |=> !o_ready)
        else $error("input accepted during a control step");

    // A gain load leaves the input open.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_mode == lqi_pkg::MODE_LOAD)) |=> o_ready)
        else $error("gain load stalled the input");

    // A result appears only from the final program step.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_done_go))
        else $error("output beat raised outside the final step");

endmodule
